>>> src/dsc_pkg.sv
package dsc_pkg;

    localparam int CHAR_WIDTH    = 8;
    localparam int MATCH_WIDTH   = 31;
    localparam int LEN_WIDTH     = 5;
    localparam int CFG_WIDTH     = 64;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int PAT_BYTES_MAX = 16;

    typedef logic [CHAR_WIDTH-1:0]    char_t;
    typedef logic [LEN_WIDTH-1:0]     len_t;
    typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;

    // Register indexes on the configuration port.
    localparam cfg_idx_t CFG_PATTERN_LEN  = 2'd0;
    localparam cfg_idx_t CFG_PATTERN_LOW  = 2'd1;
    localparam cfg_idx_t CFG_PATTERN_HIGH = 2'd2;

    // Per-beat control shared by every cell of the row.
    typedef struct packed {
        logic  step;
        logic  clear;
        char_t text_char;
    } cell_ctrl_t;

endpackage

>>> src/dsc_cell.sv
module dsc_cell #(
    parameter int COUNT_WIDTH = 31
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dsc_pkg::cell_ctrl_t     ctrl,
    input  logic                    active,
    input  dsc_pkg::char_t          pattern_char,
    input  logic [COUNT_WIDTH-1:0]  below_count,
    output logic [COUNT_WIDTH-1:0]  count,
    output logic [COUNT_WIDTH-1:0]  count_upd
);

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH:0]   sum;
    logic                   hit;

    assign sum = {1'b0, count_reg} + {1'b0, below_count};
    assign hit = active && (ctrl.text_char == pattern_char);

    // The limit is all ones, so a carry out means the sum passed it.
    always_comb
    begin
        if (hit)
        begin
            count_upd = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
        end
        else
        begin
            count_upd = count_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.step)
        begin
            count_next = ctrl.clear ? '0 : count_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

>>> src/distinct_subsequence_counter.sv
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   s_tdata = text_char, s_tlast = text_last
// m_        out  m_tvalid/m_tready   m_tdata = match_count, m_tuser = count_saturated,
//                                    m_tlast = result_last
// cfg_      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte per cycle: every prefix cell adds its left neighbor's old count in
// the same cycle, and the result is written to the output register by the
// edge that accepts the beat. The input is stalled only while a result waits
// and m_tready is low. Reset clears the registers and all counters; no clearing
// pass is needed. cfg_ready is always high.
module distinct_subsequence_counter #(
    parameter int PATTERN_MAX = 16,
    parameter int COUNT_WIDTH = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] text_char
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [30:0] match_count, [31] zero
    output logic                          m_tuser,   // [0] count_saturated
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  dsc_pkg::cfg_idx_t             cfg_index,
    input  logic [dsc_pkg::CFG_WIDTH-1:0] cfg_data
);

    localparam int PW = dsc_pkg::CHAR_WIDTH * dsc_pkg::PAT_BYTES_MAX;

    dsc_pkg::len_t                   pattern_len_reg;
    logic [PW-1:0]                   pattern_reg;
    logic                            out_valid_reg;
    logic [dsc_pkg::MATCH_WIDTH-1:0] out_count_reg;
    logic                            out_sat_reg;
    logic                            out_last_reg;

    dsc_pkg::len_t                   len_eff;
    dsc_pkg::cell_ctrl_t             ctrl;
    logic                            accept;
    logic [COUNT_WIDTH-1:0]          counts [PATTERN_MAX];
    logic [COUNT_WIDTH-1:0]          upds   [PATTERN_MAX];
    logic [COUNT_WIDTH-1:0]          sel_count;
    logic                            sel_sat;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    assign len_eff = (pattern_len_reg > dsc_pkg::LEN_WIDTH'(PATTERN_MAX))
                   ? dsc_pkg::LEN_WIDTH'(PATTERN_MAX) : pattern_len_reg;

    assign ctrl.step      = accept;
    assign ctrl.clear     = s_tlast;
    assign ctrl.text_char = s_tdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg <= '0;
            pattern_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dsc_pkg::CFG_PATTERN_LEN:
                begin
                    pattern_len_reg <= cfg_data[dsc_pkg::LEN_WIDTH-1:0];
                end
                dsc_pkg::CFG_PATTERN_LOW:
                begin
                    pattern_reg[PW/2-1:0] <= cfg_data;
                end
                dsc_pkg::CFG_PATTERN_HIGH:
                begin
                    pattern_reg[PW-1:PW/2] <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_cell
        logic [COUNT_WIDTH-1:0] below;

        if (j == 0)
        begin : g_first
            assign below = COUNT_WIDTH'(1);
        end
        else
        begin : g_rest
            assign below = counts[j-1];
        end

        dsc_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .active       (dsc_pkg::LEN_WIDTH'(j) < len_eff),
            .pattern_char (pattern_reg[j*dsc_pkg::CHAR_WIDTH +: dsc_pkg::CHAR_WIDTH]),
            .below_count  (below),
            .count        (counts[j]),
            .count_upd    (upds[j])
        );
    end

    // An empty pattern always counts one and never saturates.
    always_comb
    begin
        sel_count = COUNT_WIDTH'(1);
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if (len_eff == dsc_pkg::LEN_WIDTH'(j + 1))
            begin
                sel_count = upds[j];
            end
        end
        sel_sat = (sel_count == {COUNT_WIDTH{1'b1}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_count_reg <= '0;
            out_sat_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (accept)
        begin
            out_count_reg <= dsc_pkg::MATCH_WIDTH'(sel_count);
            out_sat_reg   <= sel_sat;
            out_last_reg  <= s_tlast;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg};
    assign m_tuser  = out_sat_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [dsc_pkg::MATCH_WIDTH-1:0] COUNT_LIMIT = {dsc_pkg::MATCH_WIDTH{1'b1}};
    localparam dsc_pkg::cfg_idx_t CFG_UNUSED_IDX = 2'd3;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 60;
    localparam int TEXT_TARGET = 850;

    typedef struct packed {
        logic [dsc_pkg::MATCH_WIDTH-1:0] count;
        logic                            saturated;
        logic                            last;
    } count_beat_t;

    // Keeps its own row of prefix counters and the pattern registers, and
    // queues the count each accepted text byte should produce.
    class count_scoreboard;
        logic [dsc_pkg::MATCH_WIDTH-1:0] prefix_count [dsc_pkg::PAT_BYTES_MAX];
        dsc_pkg::len_t                   pat_len;
        logic [dsc_pkg::CFG_WIDTH-1:0]   pat_low;
        logic [dsc_pkg::CFG_WIDTH-1:0]   pat_high;
        count_beat_t                     expected_q [$];
        int                              mismatches;

        function new();
            foreach (prefix_count[k])
                prefix_count[k] = '0;
            pat_len    = '0;
            pat_low    = '0;
            pat_high   = '0;
            mismatches = 0;
        endfunction

        function dsc_pkg::char_t pattern_byte(int j);
            if (j < 8)
                return pat_low[j*8 +: 8];
            return pat_high[(j-8)*8 +: 8];
        endfunction

        function logic [dsc_pkg::MATCH_WIDTH-1:0] sat_add(
            logic [dsc_pkg::MATCH_WIDTH-1:0] a,
            logic [dsc_pkg::MATCH_WIDTH-1:0] b);
            logic [dsc_pkg::MATCH_WIDTH:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            if (sum > {1'b0, COUNT_LIMIT})
                return COUNT_LIMIT;
            return sum[dsc_pkg::MATCH_WIDTH-1:0];
        endfunction

        function void write_reg(dsc_pkg::cfg_idx_t idx, logic [dsc_pkg::CFG_WIDTH-1:0] value);
            case (idx)
                dsc_pkg::CFG_PATTERN_LEN:  pat_len  = value[dsc_pkg::LEN_WIDTH-1:0];
                dsc_pkg::CFG_PATTERN_LOW:  pat_low  = value;
                dsc_pkg::CFG_PATTERN_HIGH: pat_high = value;
                default: ;
            endcase
        endfunction

        function void note_text(dsc_pkg::char_t ch, logic last);
            int                              n;
            logic [dsc_pkg::MATCH_WIDTH-1:0] below;
            count_beat_t                     beat;
            n = (pat_len > dsc_pkg::PAT_BYTES_MAX) ? dsc_pkg::PAT_BYTES_MAX : int'(pat_len);
            // Longest prefix first, so each counter sees its neighbor's old value.
            for (int j = n; j >= 1; j--) begin
                if (ch == pattern_byte(j - 1)) begin
                    below = (j == 1) ? dsc_pkg::MATCH_WIDTH'(1) : prefix_count[j-2];
                    prefix_count[j-1] = sat_add(prefix_count[j-1], below);
                end
            end
            beat.count     = (n == 0) ? dsc_pkg::MATCH_WIDTH'(1) : prefix_count[n-1];
            beat.saturated = (beat.count == COUNT_LIMIT);
            beat.last      = last;
            expected_q.push_back(beat);
            if (last)
                foreach (prefix_count[k])
                    prefix_count[k] = '0;
        endfunction

        function void check_count(logic [31:0] tdata, logic tuser, logic tlast);
            count_beat_t beat;
            if (expected_q.size() == 0) begin
                $display("%0t: result with none expected: tdata %h tuser %b tlast %b",
                         $time, tdata, tuser, tlast);
                mismatches++;
                return;
            end
            beat = expected_q.pop_front();
            if (tdata !== {1'b0, beat.count}) begin
                $display("%0t: match_count expected %0d, actual %0d (tdata %h)",
                         $time, beat.count, tdata[dsc_pkg::MATCH_WIDTH-1:0], tdata);
                mismatches++;
            end
            if (tuser !== beat.saturated) begin
                $display("%0t: count_saturated expected %b, actual %b",
                         $time, beat.saturated, tuser);
                mismatches++;
            end
            if (tlast !== beat.last) begin
                $display("%0t: result_last expected %b, actual %b",
                         $time, beat.last, tlast);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    s_tdata;    // [7:0] text_char
    logic                          s_tlast;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [31:0]                   m_tdata;    // [30:0] match_count, [31] zero
    logic                          m_tuser;    // [0] count_saturated
    logic                          m_tlast;
    logic                          cfg_valid;
    logic                          cfg_ready;
    dsc_pkg::cfg_idx_t             cfg_index;
    logic [dsc_pkg::CFG_WIDTH-1:0] cfg_data;

    count_scoreboard counts;
    bit              gaps_on;
    int              holds_asked;
    int              holds_done;
    int              texts_sent;

    distinct_subsequence_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic send_text(input dsc_pkg::char_t ch, input logic last);
        while (gaps_on && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        counts.note_text(ch, last);
        texts_sent++;
    endtask

    // The sender stops until every count it is owed has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (counts.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input dsc_pkg::cfg_idx_t idx,
                             input logic [dsc_pkg::CFG_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        counts.write_reg(idx, value);
    endtask

    task automatic set_pattern(input logic [dsc_pkg::CFG_WIDTH-1:0] len_word,
                               input logic [dsc_pkg::CFG_WIDTH-1:0] low,
                               input logic [dsc_pkg::CFG_WIDTH-1:0] high,
                               input bit poke_unused);
        if (poke_unused)
            write_reg(CFG_UNUSED_IDX, {$urandom, $urandom});
        write_reg(dsc_pkg::CFG_PATTERN_LEN, len_word);
        write_reg(dsc_pkg::CFG_PATTERN_LOW, low);
        write_reg(dsc_pkg::CFG_PATTERN_HIGH, high);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int phase);
        dsc_pkg::char_t alpha [4];
        int             alpha_n;
        int             len;
        int             ntexts;
        int             tlen;
        int unsigned    r;
        logic [127:0]   pat;
        dsc_pkg::char_t ch;
        bit             open_end;
        alpha_n = $urandom_range(4, 1);
        foreach (alpha[k])
            alpha[k] = dsc_pkg::char_t'($urandom_range(255));
        r = $urandom_range(99);
        if (phase % 5 == 4) begin
            // One repeated byte against a long run of it drives the count to its limit.
            alpha_n = 1;
            len = ($urandom_range(1) == 1) ? 16 : 12;
        end else if (r < 10)
            len = 0;
        else if (r < 25)
            len = 16;
        else if (r < 33)
            len = $urandom_range(31, 17);
        else
            len = $urandom_range(6, 1);
        for (int k = 0; k < dsc_pkg::PAT_BYTES_MAX; k++)
            pat[k*8 +: 8] = (k < len) ? alpha[$urandom_range(alpha_n - 1)]
                                      : dsc_pkg::char_t'($urandom_range(255));
        set_pattern({$urandom, $urandom_range(7) * 32'd32 + 32'(len)}, pat[63:0], pat[127:64],
                    $urandom_range(3) == 0);
        if (phase % 5 == 4) begin
            for (int i = 0; i < 60; i++)
                send_text(alpha[0], i == 59);
            return;
        end
        ntexts   = $urandom_range(4, 2);
        open_end = ($urandom_range(4) == 0);
        for (int t = 0; t < ntexts; t++) begin
            tlen = $urandom_range(24, 1);
            for (int i = 0; i < tlen; i++) begin
                ch = ($urandom_range(99) < 80) ? alpha[$urandom_range(alpha_n - 1)]
                                               : dsc_pkg::char_t'($urandom_range(255));
                send_text(ch, (i == tlen - 1) && !(open_end && t == ntexts - 1));
            end
        end
    endtask

    initial begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (holds_done != holds_asked) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                m_tready <= !gaps_on || ($urandom_range(99) >= 27);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            counts.check_count(m_tdata, m_tuser, m_tlast);

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        counts      = new();
        gaps_on     = 1'b1;
        holds_asked = 0;
        holds_done  = 0;
        texts_sent  = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = dsc_pkg::CFG_PATTERN_LEN;
        cfg_data    = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty pattern straight out of reset: every byte counts one.
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b1);
        drain();

        // Extreme bytes, then a shorter pattern while the text is still open.
        set_pattern(64'd3, 64'hFFFF_FFFF_FF00_FF00, {dsc_pkg::CFG_WIDTH{1'b1}}, 1'b1);
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b0);
        drain();
        set_pattern(64'd2, 64'hFFFF_FFFF_FF00_FF00, {dsc_pkg::CFG_WIDTH{1'b1}}, 1'b0);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b1);
        drain();

        // A length beyond the row is clipped to the full sixteen bytes.
        set_pattern(64'd31, 64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908, 1'b0);
        for (int k = 0; k < dsc_pkg::PAT_BYTES_MAX; k++)
            send_text(dsc_pkg::char_t'(k), k == dsc_pkg::PAT_BYTES_MAX - 1);
        drain();

        for (int phase = 0; texts_sent < TEXT_TARGET; phase++) begin
            gaps_on = (phase != 3 && phase != 4);
            if (phase == 1 || phase == 9)
                holds_asked++;
            random_phase(phase);
            drain();
        end

        if (counts.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
